[rtl/core/pmfc_pkg.sv]
package pmfc_pkg;

	// window and field sizes
	localparam int WINDOW  = 10;
	localparam int FILL_W  = $clog2(WINDOW);
	localparam int PASS_W  = $clog2(WINDOW);
	localparam int DATA_W  = 32;
	localparam int CLASS_W = 2;
	localparam int INDEX_W = 2;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_BAND_A_MIN = 2'd0;
	localparam logic [INDEX_W-1:0] REG_BAND_A_MAX = 2'd1;
	localparam logic [INDEX_W-1:0] REG_BAND_B_MIN = 2'd2;
	localparam logic [INDEX_W-1:0] REG_BAND_B_MAX = 2'd3;

	// register reset values
	localparam logic [DATA_W-1:0] BAND_A_MIN_RST = 32'd9091;
	localparam logic [DATA_W-1:0] BAND_A_MAX_RST = 32'd11111;
	localparam logic [DATA_W-1:0] BAND_B_MIN_RST = 32'd6251;
	localparam logic [DATA_W-1:0] BAND_B_MAX_RST = 32'd7142;

	// class codes
	localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_A    = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_B    = 2'd2;

	// controller state
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SORT = 4'b0010,
		ST_MED  = 4'b0100,
		ST_CLS  = 4'b1000
	} pmfc_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sort_en;
		logic sort_odd;
		logic med_en;
		logic cls_en;
	} pmfc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic window_full;
	} pmfc_stat_t;

endpackage

[rtl/core/pmfc_ctrl.sv]
module pmfc_ctrl import pmfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pmfc_stat_t stat,
	output pmfc_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	pmfc_state_t       state_q;
	logic [PASS_W-1:0] pass_q;
	logic              done_q;
	logic              accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	// commands to the datapath
	always_comb begin
		cmd.accept   = accept;
		cmd.sort_en  = (state_q == ST_SORT);
		cmd.sort_odd = pass_q[0];
		cmd.med_en   = (state_q == ST_MED);
		cmd.cls_en   = (state_q == ST_CLS);
	end

	// sequencer: accept, sort passes, median, classify
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_CLS);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && stat.window_full) begin
						state_q <= ST_SORT;
						pass_q  <= '0;
					end
				end
				ST_SORT: begin
					if (pass_q == PASS_W'(WINDOW - 1)) begin
						state_q <= ST_MED;
					end else begin
						pass_q <= pass_q + 1'b1;
					end
				end
				ST_MED: begin
					state_q <= ST_CLS;
				end
				ST_CLS: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/pmfc_datapath.sv]
module pmfc_datapath import pmfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pmfc_cmd_t           cmd,
	output pmfc_stat_t          stat,
	input  logic [DATA_W-1:0]   edge_time_us,
	input  logic                cfg_we,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]   cfg_wdata,
	output logic [DATA_W-1:0]   median_interval_us,
	output logic [CLASS_W-1:0]  band_class
);

	logic [DATA_W-1:0]  band_a_min_q;
	logic [DATA_W-1:0]  band_a_max_q;
	logic [DATA_W-1:0]  band_b_min_q;
	logic [DATA_W-1:0]  band_b_max_q;
	logic [DATA_W-1:0]  last_edge_q;
	logic [FILL_W-1:0]  fill_q;
	logic [DATA_W-1:0]  store_q [WINDOW];
	logic [DATA_W-1:0]  med_q;
	logic [CLASS_W-1:0] class_q;
	logic [DATA_W-1:0]  interval;
	logic               nonzero;
	logic [DATA_W:0]    mid_sum;
	logic [DATA_W-1:0]  median_c;
	logic [CLASS_W-1:0] class_c;

	// interval since previous edge, modulo 2^32
	assign interval = edge_time_us - last_edge_q;
	assign nonzero  = (interval != '0);
	assign stat.window_full = nonzero && (fill_q == FILL_W'(WINDOW - 1));

	// band registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_a_min_q <= BAND_A_MIN_RST;
			band_a_max_q <= BAND_A_MAX_RST;
			band_b_min_q <= BAND_B_MIN_RST;
			band_b_max_q <= BAND_B_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_A_MIN: band_a_min_q <= cfg_wdata;
				REG_BAND_A_MAX: band_a_max_q <= cfg_wdata;
				REG_BAND_B_MIN: band_b_min_q <= cfg_wdata;
				REG_BAND_B_MAX: band_b_max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// edge time and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			fill_q      <= '0;
		end else if (cmd.accept) begin
			last_edge_q <= edge_time_us;
			if (nonzero) begin
				if (fill_q == FILL_W'(WINDOW - 1)) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// window store: fill on request, odd-even transposition sort in place
	always_ff @(posedge clk) begin
		if (cmd.accept && nonzero) begin
			store_q[fill_q] <= interval;
		end else if (cmd.sort_en) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				if ((i[0] == cmd.sort_odd) && (store_q[i] > store_q[i+1])) begin
					store_q[i]   <= store_q[i+1];
					store_q[i+1] <= store_q[i];
				end
			end
		end
	end

	// median of the sorted window
	always_comb begin
		mid_sum = {1'b0, store_q[WINDOW/2 - 1]} + {1'b0, store_q[WINDOW/2]};
		if ((WINDOW % 2) == 0) begin
			median_c = mid_sum[DATA_W:1];
		end else begin
			median_c = store_q[WINDOW/2];
		end
	end

	// band check, band a first
	always_comb begin
		if ((med_q >= band_a_min_q) && (med_q <= band_a_max_q)) begin
			class_c = CLASS_A;
		end else if ((med_q >= band_b_min_q) && (med_q <= band_b_max_q)) begin
			class_c = CLASS_B;
		end else begin
			class_c = CLASS_NONE;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.med_en) begin
			med_q <= median_c;
		end
		if (cmd.cls_en) begin
			class_q <= class_c;
		end
	end

	assign median_interval_us = med_q;
	assign band_class         = class_q;

endmodule

[rtl/core/pulse_median_frequency_classifier_top.sv]
// Pulse median frequency classifier. Each request on start carries the timestamp of
// a rising edge; the block keeps the interval since the previous edge (modulo 2^32,
// the first one measured from zero), drops zero intervals, and once a window of
// WINDOW (10) nonzero intervals is collected sorts it, takes the median and checks it
// against the band A and band B registers (band A first). A request that does not
// complete the window is taken in one cycle and start may be held high for the next
// one. A request that completes the window keeps busy high through WINDOW passes of
// an odd-even transposition sort over the stored window, a median step and a band
// check step. done then pulses for one cycle with median_interval_us and band_class
// as busy falls; the result is shown once and cannot be held off, so it must be
// captured then. Band registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while idle (not enforced by the block).
module pulse_median_frequency_classifier_top import pmfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [DATA_W-1:0]   edge_time_us,
	output logic                done,
	output logic [DATA_W-1:0]   median_interval_us,
	output logic [CLASS_W-1:0]  band_class,
	input  logic                cfg_we,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]   cfg_wdata
);

	pmfc_cmd_t  cmd;
	pmfc_stat_t stat;

	// controller
	pmfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath
	pmfc_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.edge_time_us       (edge_time_us),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.median_interval_us (median_interval_us),
		.band_class         (band_class)
	);

endmodule

[rtl/core/pmfc_checker.sv]
module pmfc_checker import pmfc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [CLASS_W-1:0] band_class
);

	// a result appears only as the block goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a window needs many requests, so results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done in consecutive cycles");

	// class code is one of the three defined codes
	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (band_class == CLASS_NONE || band_class == CLASS_A ||
			band_class == CLASS_B))
		else $error("undefined band class");

	// busy only follows a taken request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without request");

	// every busy period ends with a result
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without result");

endmodule

bind pulse_median_frequency_classifier_top pmfc_checker u_pmfc_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import pmfc_pkg::*;

	localparam int LATENCY     = WINDOW + 3;
	localparam int MAX_CYCLES  = 400000;
	localparam int PHASE_ITEMS = 175;
	localparam int ROW_COUNT   = 23;

	typedef struct {
		logic [DATA_W-1:0]  median;
		logic [CLASS_W-1:0] cls;
	} band_result_t;

	typedef struct {
		logic [DATA_W-1:0]  stamp;
		bit                 typed;
		logic [DATA_W-1:0]  median;
		logic [CLASS_W-1:0] cls;
	} edge_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [DATA_W-1:0]  edge_time_us = '0;
	logic               cfg_we       = 1'b0;
	logic [INDEX_W-1:0] cfg_index    = '0;
	logic [DATA_W-1:0]  cfg_wdata    = '0;
	logic               busy;
	logic               done;
	logic [DATA_W-1:0]  median_interval_us;
	logic [CLASS_W-1:0] band_class;

	// local copy of the band registers and the edge history
	logic [DATA_W-1:0] band_a_lo;
	logic [DATA_W-1:0] band_a_hi;
	logic [DATA_W-1:0] band_b_lo;
	logic [DATA_W-1:0] band_b_hi;
	logic [DATA_W-1:0] prev_edge_us;
	logic [DATA_W-1:0] interval_win [WINDOW];
	int                win_count;
	logic [DATA_W-1:0] window_base;

	band_result_t pending_results[$];
	int           mismatches = 0;
	int           cycles     = 0;
	int           calm_left  = 0;

	// directed edges: zero intervals, steady window, timestamp wrap, extremes
	edge_row_t dir_rows [ROW_COUNT] = '{
		'{32'd0,          1'b0, 32'd0,     CLASS_NONE},
		'{32'd10000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd20000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd30000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd40000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd50000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd60000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd70000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd80000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd90000,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd100000,     1'b1, 32'd10000, CLASS_A},
		'{32'd100000,     1'b0, 32'd0,     CLASS_NONE},
		'{32'hFFFF_FFFF,  1'b0, 32'd0,     CLASS_NONE},
		'{32'd6499,       1'b0, 32'd0,     CLASS_NONE},
		'{32'd12999,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd12999,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd19499,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd25999,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd32499,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd38999,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd45499,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd51999,      1'b0, 32'd0,     CLASS_NONE},
		'{32'd58499,      1'b1, 32'd6500,  CLASS_B}
	};

	pulse_median_frequency_classifier_top u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.edge_time_us       (edge_time_us),
		.done               (done),
		.median_interval_us (median_interval_us),
		.band_class         (band_class),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata)
	);

	// clock
	always #5 clk = ~clk;

	// median of the stored window, exact 33-bit sum for an even window
	function automatic logic [DATA_W-1:0] window_median();
		logic [DATA_W-1:0] s [WINDOW];
		logic [DATA_W-1:0] v;
		logic [DATA_W:0]   mid_sum;
		int                i;
		int                j;
		s = interval_win;
		for (i = 1; i < WINDOW; i++) begin
			v = s[i];
			j = i;
			while (j > 0 && s[j-1] > v) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = v;
		end
		if (WINDOW % 2 == 0) begin
			mid_sum = {1'b0, s[WINDOW/2-1]} + {1'b0, s[WINDOW/2]};
			return mid_sum[DATA_W:1];
		end
		return s[WINDOW/2];
	endfunction

	// band a is tested first, an empty band never matches
	function automatic logic [CLASS_W-1:0] band_of(input logic [DATA_W-1:0] med);
		if (med >= band_a_lo && med <= band_a_hi)
			return CLASS_A;
		if (med >= band_b_lo && med <= band_b_hi)
			return CLASS_B;
		return CLASS_NONE;
	endfunction

	// advance the edge history by one accepted edge
	task automatic record_edge(input logic [DATA_W-1:0] stamp, output bit has_result,
			output band_result_t res);
		logic [DATA_W-1:0] interval;
		interval     = stamp - prev_edge_us;
		prev_edge_us = stamp;
		has_result   = 1'b0;
		res          = '{'0, CLASS_NONE};
		if (interval != 0) begin
			interval_win[win_count] = interval;
			win_count++;
			if (win_count == WINDOW) begin
				res.median = window_median();
				res.cls    = band_of(res.median);
				win_count  = 0;
				has_result = 1'b1;
			end
		end
	endtask

	// idle length between requests, with occasional runs of back-to-back requests
	function automatic int pick_gap();
		int pick;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		if (pick < 40)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// interval around which a window is built, often on a band edge
	function automatic logic [DATA_W-1:0] pick_base();
		case ($urandom_range(0, 11))
			0: return band_a_lo - 1;
			1: return band_a_lo;
			2: return band_a_hi;
			3: return band_a_hi + 1;
			4: return band_b_lo - 1;
			5: return band_b_lo;
			6: return band_b_hi;
			7: return band_b_hi + 1;
			8: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			9: return $urandom();
			default: return $urandom_range(1, 20000);
		endcase
	endfunction

	// next timestamp: mostly steady windows, some zero intervals, jumps and noise
	function automatic logic [DATA_W-1:0] next_stamp();
		int pick;
		if (win_count == 0)
			window_base = pick_base();
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return prev_edge_us;
		if (pick < 6)
			return $urandom();
		if (pick < 9)
			return prev_edge_us + $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
		if (pick < 40)
			return prev_edge_us + window_base + $urandom_range(0, 6) - 3;
		return prev_edge_us + window_base;
	endfunction

	// one edge request, held until taken, then an optional gap
	task automatic send_edge(input logic [DATA_W-1:0] stamp, input bit typed,
			input band_result_t typed_res);
		bit           has_result;
		band_result_t res;
		int           gap;
		start        <= 1'b1;
		edge_time_us <= stamp;
		do
			@(posedge clk);
		while (busy);
		record_edge(stamp, has_result, res);
		if (typed)
			pending_results.push_back(typed_res);
		else if (has_result)
			pending_results.push_back(res);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop requests and let every pending median come out
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// write all four band registers while idle
	task automatic write_bands(input logic [DATA_W-1:0] a_lo, input logic [DATA_W-1:0] a_hi,
			input logic [DATA_W-1:0] b_lo, input logic [DATA_W-1:0] b_hi);
		logic [DATA_W-1:0]  vals [4];
		logic [INDEX_W-1:0] idx [4];
		int                 k;
		vals = '{a_lo, a_hi, b_lo, b_hi};
		idx  = '{REG_BAND_A_MIN, REG_BAND_A_MAX, REG_BAND_B_MIN, REG_BAND_B_MAX};
		drain();
		for (k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= vals[k];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		band_a_lo = a_lo;
		band_a_hi = a_hi;
		band_b_lo = b_lo;
		band_b_hi = b_hi;
	endtask

	// one band setting followed by random edges
	task automatic run_phase(input logic [DATA_W-1:0] a_lo, input logic [DATA_W-1:0] a_hi,
			input logic [DATA_W-1:0] b_lo, input logic [DATA_W-1:0] b_hi);
		band_result_t no_typed;
		int           n;
		no_typed = '{'0, CLASS_NONE};
		write_bands(a_lo, a_hi, b_lo, b_hi);
		for (n = 0; n < PHASE_ITEMS; n++)
			send_edge(next_stamp(), 1'b0, no_typed);
	endtask

	// compare each result with the oldest pending median
	always @(posedge clk) begin : check_results
		band_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: median %0d class %0d",
						median_interval_us, band_class);
			end else begin
				want = pending_results.pop_front();
				if (median_interval_us !== want.median || band_class !== want.cls) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: median exp %0d got %0d, class exp %0d got %0d",
							want.median, median_interval_us, want.cls, band_class);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		band_result_t      row_res;
		logic [DATA_W-1:0] lo_a;
		logic [DATA_W-1:0] lo_b;
		int                r;
		band_a_lo    = BAND_A_MIN_RST;
		band_a_hi    = BAND_A_MAX_RST;
		band_b_lo    = BAND_B_MIN_RST;
		band_b_hi    = BAND_B_MAX_RST;
		prev_edge_us = '0;
		win_count    = 0;
		window_base  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed edges under the reset bands
		for (r = 0; r < ROW_COUNT; r++) begin
			row_res = '{dir_rows[r].median, dir_rows[r].cls};
			send_edge(dir_rows[r].stamp, dir_rows[r].typed, row_res);
		end

		// full overlap, band a wins
		run_phase(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		// band a empty
		run_phase(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
		// both bands empty
		run_phase(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
		// narrow nearby bands that can overlap
		lo_a = $urandom_range(1, 15000);
		lo_b = lo_a + $urandom_range(0, 3000);
		run_phase(lo_a, lo_a + $urandom_range(0, 4000), lo_b, lo_b + $urandom_range(0, 4000));
		// arbitrary bands
		run_phase($urandom(), $urandom(), $urandom(), $urandom());
		// back to the reset bands
		run_phase(BAND_A_MIN_RST, BAND_A_MAX_RST, BAND_B_MIN_RST, BAND_B_MAX_RST);

		drain();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
